>>> hw/rtl/tmw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmw_pkg
// Shared types and constants of the transition mask weight core.
// ----------------------------------------------------------------------------
package tmw_pkg;

    // Q1.16 unity and centre
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    // Stage counts of the three sections
    localparam int PROG_STEPS = 16;
    localparam int SQRT_STEPS = 17;
    localparam int EDGE_STEPS = 17;
    localparam int PROG_LAT   = PROG_STEPS + 1;
    localparam int SQRT_LAT   = SQRT_STEPS + 2;
    localparam int EDGE_LAT   = EDGE_STEPS + 5;
    localparam int CORE_LAT   = PROG_LAT + SQRT_LAT + EDGE_LAT;

    // Register indexes of the write port
    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_INVERT = 3'd1,
        REG_BLUR   = 3'd2,
        REG_START  = 3'd3,
        REG_END    = 3'd4
    } t_reg_idx;

    // Transition modes
    typedef enum logic [1:0] {
        MODE_FADE   = 2'd0,
        MODE_HWIPE  = 2'd1,
        MODE_VWIPE  = 2'd2,
        MODE_CIRCLE = 2'd3
    } t_mode;

    // Progress classification
    typedef enum logic [1:0] {
        PK_ZERO = 2'd0,
        PK_FULL = 2'd1,
        PK_DIV  = 2'd2
    } t_pkind;

    // Weight rule picked at the front of the edge section
    typedef enum logic [1:0] {
        WK_FADE = 2'd0,
        WK_HARD = 2'd1,
        WK_SOFT = 2'd2
    } t_wkind;

    typedef struct packed {
        logic [1:0]  mode;
        logic        invert;
        logic [18:0] blur;
        logic [19:0] start_frame;
        logic [19:0] end_frame;
    } t_cfg;

    typedef struct packed {
        logic [16:0] x;
        logic [16:0] y;
    } t_xy;

endpackage
`default_nettype wire

>>> hw/rtl/tmw_prog.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmw_prog
// Progress pipeline: classifies the frame and runs a 16 stage long division
// of (frame - start) * 65536 by (end - start), one quotient bit per stage.
// ----------------------------------------------------------------------------
module tmw_prog (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tmw_pkg::t_cfg     i_cfg,
    input  wire logic              i_valid,
    input  wire logic [19:0]       i_frame,
    input  wire logic [16:0]       i_pos_x,
    input  wire logic [16:0]       i_pos_y,
    output logic                   o_valid,
    output logic [16:0]            o_prog,
    output tmw_pkg::t_xy           o_xy
);
    import tmw_pkg::*;

    logic        r_valid [0:PROG_STEPS];
    t_pkind      r_kind  [0:PROG_STEPS];
    logic [19:0] r_rem   [0:PROG_STEPS];
    logic [19:0] r_den   [0:PROG_STEPS];
    logic [15:0] r_quo   [0:PROG_STEPS];
    t_xy         r_xy    [0:PROG_STEPS];

    t_pkind      n_kind;
    t_xy         n_xy;

    // Entry: saturate positions, classify the frame
    always_comb begin
        n_xy.x = (i_pos_x > ONE_Q16) ? ONE_Q16 : i_pos_x;
        n_xy.y = (i_pos_y > ONE_Q16) ? ONE_Q16 : i_pos_y;
        if (i_cfg.end_frame <= i_cfg.start_frame) begin
            n_kind = PK_FULL;
        end else if (i_frame <= i_cfg.start_frame) begin
            n_kind = PK_ZERO;
        end else if (i_frame >= i_cfg.end_frame) begin
            n_kind = PK_FULL;
        end else begin
            n_kind = PK_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind[0] <= n_kind;
        r_rem[0]  <= i_frame - i_cfg.start_frame;
        r_den[0]  <= i_cfg.end_frame - i_cfg.start_frame;
        r_quo[0]  <= '0;
        r_xy[0]   <= n_xy;
    end

    // Division steps: for a divided frame the remainder stays below the divisor
    for (genvar k = 1; k <= PROG_STEPS; k++) begin : g_step
        logic [20:0] w_rem2;
        logic        w_ge;
        assign w_rem2 = {r_rem[k-1], 1'b0};
        assign w_ge   = (w_rem2 >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_kind[k] <= r_kind[k-1];
            r_den[k]  <= r_den[k-1];
            r_xy[k]   <= r_xy[k-1];
            r_quo[k]  <= {r_quo[k-1][14:0], w_ge};
            r_rem[k]  <= w_ge ? 20'(w_rem2 - {1'b0, r_den[k-1]}) : w_rem2[19:0];
        end
    end

    // Final selection of the progress value
    always_comb begin
        unique case (r_kind[PROG_STEPS])
            PK_ZERO: o_prog = '0;
            PK_FULL: o_prog = ONE_Q16;
            PK_DIV:  o_prog = {1'b0, r_quo[PROG_STEPS]};
            default: o_prog = ONE_Q16;
        endcase
    end

    assign o_valid = r_valid[PROG_STEPS];
    assign o_xy    = r_xy[PROG_STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/tmw_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmw_sqrt
// Radius pipeline: squares the centred offsets, then a 17 stage digit by
// digit square root of 2 * (dx^2 + dy^2), two radicand bits per stage.
// ----------------------------------------------------------------------------
module tmw_sqrt (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [16:0]       i_prog,
    input  wire tmw_pkg::t_xy      i_xy,
    output logic                   o_valid,
    output logic [16:0]            o_prog,
    output tmw_pkg::t_xy           o_xy,
    output logic [16:0]            o_root
);
    import tmw_pkg::*;

    logic signed [17:0] w_dx;
    logic signed [17:0] w_dy;
    logic signed [35:0] w_dx2;
    logic signed [35:0] w_dy2;

    // Stage one: squares
    logic        r_sq_valid;
    logic [30:0] r_sqx;
    logic [30:0] r_sqy;
    logic [16:0] r_sq_prog;
    t_xy         r_sq_xy;

    // Root steps, entry 0 is the radicand stage
    logic        r_valid [0:SQRT_STEPS];
    logic [33:0] r_rad   [0:SQRT_STEPS];
    logic [19:0] r_rem   [0:SQRT_STEPS];
    logic [16:0] r_root  [0:SQRT_STEPS];
    logic [16:0] r_prog  [0:SQRT_STEPS];
    t_xy         r_xy    [0:SQRT_STEPS];

    assign w_dx  = $signed({1'b0, i_xy.x}) - $signed({1'b0, HALF_Q16});
    assign w_dy  = $signed({1'b0, i_xy.y}) - $signed({1'b0, HALF_Q16});
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
            r_valid[0] <= 1'b0;
        end else begin
            r_sq_valid <= i_valid;
            r_valid[0] <= r_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqx     <= w_dx2[30:0];
        r_sqy     <= w_dy2[30:0];
        r_sq_prog <= i_prog;
        r_sq_xy   <= i_xy;
        // radicand = 2 * sum, padded to an even width
        r_rad[0]  <= {1'b0, ({1'b0, r_sqx} + {1'b0, r_sqy}), 1'b0};
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_prog[0] <= r_sq_prog;
        r_xy[0]   <= r_sq_xy;
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
        logic [19:0] w_rem;
        logic [19:0] w_trial;
        logic        w_ge;
        assign w_rem   = {r_rem[k-1][17:0], r_rad[k-1][33:32]};
        assign w_trial = {1'b0, r_root[k-1], 2'b01};
        assign w_ge    = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[k]  <= {r_rad[k-1][31:0], 2'b00};
            r_rem[k]  <= w_ge ? (w_rem - w_trial) : w_rem;
            r_root[k] <= {r_root[k-1][15:0], w_ge};
            r_prog[k] <= r_prog[k-1];
            r_xy[k]   <= r_xy[k-1];
        end
    end

    assign o_valid = r_valid[SQRT_STEPS];
    assign o_prog  = r_prog[SQRT_STEPS];
    assign o_xy    = r_xy[SQRT_STEPS];
    assign o_root  = r_root[SQRT_STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/tmw_edge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmw_edge
// Weight pipeline: picks the position, forms the soft edge numerator and
// divides it by the blur width in 17 stages; output register at the end.
// ----------------------------------------------------------------------------
module tmw_edge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tmw_pkg::t_cfg     i_cfg,
    input  wire logic              i_valid,
    input  wire logic [16:0]       i_prog,
    input  wire tmw_pkg::t_xy      i_xy,
    input  wire logic [16:0]       i_root,
    output logic                   o_valid,
    output logic [16:0]            o_weight
);
    import tmw_pkg::*;

    logic [16:0] w_pos;
    logic [16:0] w_t;
    t_wkind      w_kind;

    // e1: position and rule
    logic        r1_valid;
    t_wkind      r1_kind;
    logic [16:0] r1_prog;
    logic [16:0] r1_t;
    // e2: product
    logic        r2_valid;
    t_wkind      r2_kind;
    logic [16:0] r2_prog;
    logic [16:0] r2_t;
    logic        r2_lt;
    logic [36:0] r2_prod;
    // e3: numerator
    logic        r3_valid;
    t_wkind      r3_kind;
    logic [16:0] r3_prog;
    logic        r3_lt;
    logic        r3_nonpos;
    logic [36:0] r3_num;
    logic [37:0] w_num;

    // e4 and division steps
    logic        r_valid  [0:EDGE_STEPS];
    t_wkind      r_kind   [0:EDGE_STEPS];
    logic [16:0] r_prog   [0:EDGE_STEPS];
    logic        r_lt     [0:EDGE_STEPS];
    logic        r_nonpos [0:EDGE_STEPS];
    logic        r_sat    [0:EDGE_STEPS];
    logic [19:0] r_rem    [0:EDGE_STEPS];
    logic [16:0] r_low    [0:EDGE_STEPS];
    logic [16:0] r_quo    [0:EDGE_STEPS];

    logic        r_out_valid;
    logic [16:0] r_out_weight;
    logic [16:0] n_weight;

    // Position by mode, then optional inversion
    always_comb begin
        unique case (t_mode'(i_cfg.mode))
            MODE_HWIPE:  w_pos = i_xy.x;
            MODE_VWIPE:  w_pos = i_xy.y;
            MODE_CIRCLE: w_pos = (i_root > ONE_Q16) ? ONE_Q16 : i_root;
            default:     w_pos = i_xy.x;
        endcase
        w_t = i_cfg.invert ? (ONE_Q16 - w_pos) : w_pos;
        if (t_mode'(i_cfg.mode) == MODE_FADE) begin
            w_kind = WK_FADE;
        end else if (i_cfg.blur == '0) begin
            w_kind = WK_HARD;
        end else begin
            w_kind = WK_SOFT;
        end
    end

    assign w_num = {1'b0, r2_prod} - {5'd0, r2_t, 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            r_valid[0] <= 1'b0;
        end else begin
            r1_valid   <= i_valid;
            r2_valid   <= r1_valid;
            r3_valid   <= r2_valid;
            r_valid[0] <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_kind    <= w_kind;
        r1_prog    <= i_prog;
        r1_t       <= w_t;

        r2_kind    <= r1_kind;
        r2_prog    <= r1_prog;
        r2_t       <= r1_t;
        r2_lt      <= (r1_t < r1_prog);
        r2_prod    <= r1_prog * (20'd65536 + {1'b0, i_cfg.blur});

        r3_kind    <= r2_kind;
        r3_prog    <= r2_prog;
        r3_lt      <= r2_lt;
        r3_nonpos  <= w_num[37] || (w_num == '0);
        r3_num     <= w_num[36:0];

        // e4: quotient of 2^17 or more saturates at once
        r_kind[0]   <= r3_kind;
        r_prog[0]   <= r3_prog;
        r_lt[0]     <= r3_lt;
        r_nonpos[0] <= r3_nonpos;
        r_sat[0]    <= (r3_num[36:17] >= {1'b0, i_cfg.blur});
        r_rem[0]    <= r3_num[36:17];
        r_low[0]    <= r3_num[16:0];
        r_quo[0]    <= '0;
    end

    for (genvar k = 1; k <= EDGE_STEPS; k++) begin : g_step
        logic [19:0] w_rem2;
        logic        w_ge;
        assign w_rem2 = {r_rem[k-1][18:0], r_low[k-1][16]};
        assign w_ge   = (w_rem2 >= {1'b0, i_cfg.blur});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_kind[k]   <= r_kind[k-1];
            r_prog[k]   <= r_prog[k-1];
            r_lt[k]     <= r_lt[k-1];
            r_nonpos[k] <= r_nonpos[k-1];
            r_sat[k]    <= r_sat[k-1];
            r_low[k]    <= {r_low[k-1][15:0], 1'b0};
            r_quo[k]    <= {r_quo[k-1][15:0], w_ge};
            r_rem[k]    <= w_ge ? (w_rem2 - {1'b0, i_cfg.blur}) : w_rem2;
        end
    end

    // Final weight
    always_comb begin
        unique case (r_kind[EDGE_STEPS])
            WK_FADE: n_weight = r_prog[EDGE_STEPS];
            WK_HARD: n_weight = r_lt[EDGE_STEPS] ? ONE_Q16 : '0;
            WK_SOFT: begin
                if (r_nonpos[EDGE_STEPS]) begin
                    n_weight = '0;
                end else if (r_sat[EDGE_STEPS] || (r_quo[EDGE_STEPS] > ONE_Q16)) begin
                    n_weight = ONE_Q16;
                end else begin
                    n_weight = r_quo[EDGE_STEPS];
                end
            end
            default: n_weight = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid[EDGE_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_weight <= n_weight;
    end

    assign o_valid  = r_out_valid;
    assign o_weight = r_out_weight;

endmodule
`default_nettype wire

>>> hw/rtl/transition_mask_weight_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// transition_mask_weight_core
// Per-pixel weight of the incoming scene for fade, wipe and circle
// transitions with an optional soft edge.
// ----------------------------------------------------------------------------
// One pixel is taken on every clock in which i_start is high; o_busy is
// always low. Each pixel gives one beat on o_blend_weight, marked by o_valid,
// after passing in order through progress division (one quotient bit a
// stage), squaring and square root (two radicand bits a stage) and edge
// arithmetic and blur division, ending in the output register. The receiver
// cannot stall. Registers may be written only while no pixel is in flight.
module transition_mask_weight_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [19:0] i_frame_number,
    input  wire logic [16:0] i_pos_x,
    input  wire logic [16:0] i_pos_y,
    output logic             o_valid,
    output logic [16:0]      o_blend_weight,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_data
);
    import tmw_pkg::*;

    t_cfg        r_cfg;
    logic        w_accept;

    logic        w_pg_valid;
    logic [16:0] w_pg_prog;
    t_xy         w_pg_xy;
    logic        w_sq_valid;
    logic [16:0] w_sq_prog;
    t_xy         w_sq_xy;
    logic [16:0] w_sq_root;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_MODE:   r_cfg.mode        <= i_cfg_data[1:0];
                REG_INVERT: r_cfg.invert      <= i_cfg_data[0];
                REG_BLUR:   r_cfg.blur        <= i_cfg_data[18:0];
                REG_START:  r_cfg.start_frame <= i_cfg_data;
                REG_END:    r_cfg.end_frame   <= i_cfg_data;
                default:    r_cfg             <= r_cfg;
            endcase
        end
    end

    tmw_prog u_prog (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_accept),
        .i_frame (i_frame_number),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .o_valid (w_pg_valid),
        .o_prog  (w_pg_prog),
        .o_xy    (w_pg_xy)
    );

    tmw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pg_valid),
        .i_prog  (w_pg_prog),
        .i_xy    (w_pg_xy),
        .o_valid (w_sq_valid),
        .o_prog  (w_sq_prog),
        .o_xy    (w_sq_xy),
        .o_root  (w_sq_root)
    );

    tmw_edge u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_sq_valid),
        .i_prog   (w_sq_prog),
        .i_xy     (w_sq_xy),
        .i_root   (w_sq_root),
        .o_valid  (o_valid),
        .o_weight (o_blend_weight)
    );

    // Weight never exceeds unity
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_blend_weight <= ONE_Q16))
        else $error("blend weight above unity");

    // Every beat out traces back to a pixel taken at the input
    a_beat_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, CORE_LAT))
        else $error("result beat without a pixel");

    // Fade gives progress directly: a hard step never shows in-between values
    a_hard_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_cfg.blur == '0) && (r_cfg.mode != MODE_FADE)) |->
        ((o_blend_weight == '0) || (o_blend_weight == ONE_Q16)))
        else $error("hard edge weight not a step");

endmodule
`default_nettype wire
